[hdl/tifc_pkg.sv]
// ----------------------------------------------------------------------------
// tifc_pkg
// Shared widths, codes, constants and types of the transverse isotropic
// failure check.
// ----------------------------------------------------------------------------
package tifc_pkg;

    localparam int STRESS_W         = 32;
    localparam int SCALE_W          = 32;
    localparam int STR_W            = 31;
    localparam int THR_W            = 47;
    localparam int SQ_W             = 64;
    localparam int ROOT_W           = 32;
    localparam int NORM_W           = 20;
    localparam int MODE_W           = 3;
    localparam int CFG_IDX_W        = 3;
    localparam int ISQRT_STAGES     = ROOT_W;
    localparam int ANGLE_ITERATIONS = 16;
    localparam int VEC_W            = 35;
    localparam int CORD_W           = 44;
    localparam int ANG_W            = 32;
    localparam int TH_W             = 34;
    localparam int SHIFT_W          = 6;
    localparam int NORM_EXP         = 40;

    localparam logic [MODE_W-1:0] MODE_NONE     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_AXIAL_T  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_AXIAL_S  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_TRANS_T  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_TRANS_S  = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_GEOMETRY   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AXIAL_TENS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AXIAL_SHR  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TRANS_SHR  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_TENS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_SHR  = 3'd5;

    localparam logic signed [TH_W-1:0] PI_Q30         = 34'sd3373259426;
    localparam logic signed [TH_W-1:0] HALF_PI_Q30    = 34'sd1686629713;
    localparam logic signed [TH_W-1:0] QUARTER_PI_Q30 = 34'sd843314857;
    localparam logic signed [TH_W-1:0] ROUND_Q30      = 34'sd8192;

    localparam logic signed [NORM_W-1:0] HALF_PI_Q16 = 20'sd102944;
    localparam logic signed [NORM_W-1:0] ONE_Q16     = 20'sd65536;

    typedef struct packed {
        logic                        geom2d;
        logic [MODE_W-1:0]           mode2d;
        logic signed [NORM_W-1:0]    first2d;
        logic signed [NORM_W-1:0]    second2d;
        logic                        axial;
        logic                        tw;
        logic [THR_W-1:0]            thr_shear;
        logic [THR_W-1:0]            tp;
        logic [THR_W-1:0]            tps;
        logic signed [STRESS_W-1:0]  ssum;
        logic signed [STRESS_W:0]    d;
        logic signed [STRESS_W-1:0]  xy;
        logic signed [STRESS_W-1:0]  xz;
        logic [STRESS_W-1:0]         ayz;
    } t_sb;

    typedef struct packed {
        logic                        geom2d;
        logic [MODE_W-1:0]           mode;
        logic signed [NORM_W-1:0]    first_fix;
        logic signed [NORM_W-1:0]    second_fix;
        logic                        ang_direct;
        logic                        ang_principal;
        logic                        half_fix;
        logic                        take_first;
    } t_ctl;

    function automatic logic [STRESS_W-1:0] mag32(input logic signed [STRESS_W-1:0] v);
        logic signed [STRESS_W:0] e;
        e = v;
        if (v < 0) begin
            e = -e;
        end
        return e[STRESS_W-1:0];
    endfunction

    function automatic logic [THR_W-1:0] thr(input logic [STR_W-1:0] s,
                                             input logic [SCALE_W-1:0] k);
        logic [STR_W+SCALE_W-1:0] p;
        p = (STR_W+SCALE_W)'(s) * (STR_W+SCALE_W)'(k);
        return p[STR_W+SCALE_W-1:16];
    endfunction

    function automatic logic signed [ANG_W-1:0] atan_q30(input int i);
        logic signed [ANG_W-1:0] a;
        case (i)
            0:  a = 32'sd843314857;
            1:  a = 32'sd497837830;
            2:  a = 32'sd263043837;
            3:  a = 32'sd133525159;
            4:  a = 32'sd67021687;
            5:  a = 32'sd33543516;
            6:  a = 32'sd16775851;
            7:  a = 32'sd8388437;
            8:  a = 32'sd4194283;
            9:  a = 32'sd2097149;
            10: a = 32'sd1048576;
            11: a = 32'sd524288;
            12: a = 32'sd262144;
            13: a = 32'sd131072;
            14: a = 32'sd65536;
            15: a = 32'sd32768;
            16: a = 32'sd16384;
            17: a = 32'sd8192;
            18: a = 32'sd4096;
            19: a = 32'sd2048;
            20: a = 32'sd1024;
            21: a = 32'sd512;
            22: a = 32'sd256;
            23: a = 32'sd128;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

[hdl/tifc_in_if.sv]
// ----------------------------------------------------------------------------
// tifc_in_if
// Stress request channel: valid, ready and one stress tensor with scale.
// ----------------------------------------------------------------------------
interface tifc_in_if import tifc_pkg::*;;
    logic                       valid;
    logic                       ready;
    logic signed [STRESS_W-1:0] stress_xx;
    logic signed [STRESS_W-1:0] stress_yy;
    logic signed [STRESS_W-1:0] stress_zz;
    logic signed [STRESS_W-1:0] stress_xy;
    logic signed [STRESS_W-1:0] stress_xz;
    logic signed [STRESS_W-1:0] stress_yz;
    logic [SCALE_W-1:0]         strength_scale;

    modport source (output valid, stress_xx, stress_yy, stress_zz, stress_xy,
                    stress_xz, stress_yz, strength_scale, input ready);
    modport sink (input valid, stress_xx, stress_yy, stress_zz, stress_xy,
                  stress_xz, stress_yz, strength_scale, output ready);
endinterface

[hdl/tifc_out_if.sv]
// ----------------------------------------------------------------------------
// tifc_out_if
// Result channel: valid, ready, failure mode and crack normal.
// ----------------------------------------------------------------------------
interface tifc_out_if import tifc_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic [MODE_W-1:0]        failure_mode;
    logic signed [NORM_W-1:0] normal_first;
    logic signed [NORM_W-1:0] normal_second;

    modport source (output valid, failure_mode, normal_first, normal_second,
                    input ready);
    modport sink (input valid, failure_mode, normal_first, normal_second,
                  output ready);
endinterface

[hdl/tifc_cfg_if.sv]
// ----------------------------------------------------------------------------
// tifc_cfg_if
// Configuration write channel: valid, ready, register index and data.
// ----------------------------------------------------------------------------
interface tifc_cfg_if import tifc_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [STR_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[hdl/tifc_isqrt.sv]
// ----------------------------------------------------------------------------
// tifc_isqrt
// Pipelined floor square root, one result bit per stage.
// ----------------------------------------------------------------------------
module tifc_isqrt import tifc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [SQ_W-1:0]   i_val,
    output logic [ROOT_W-1:0] o_root
);

    logic [SQ_W-1:0] r_v [ISQRT_STAGES];
    logic [SQ_W-1:0] r_r [ISQRT_STAGES];
    logic [SQ_W-1:0] n_v [ISQRT_STAGES];
    logic [SQ_W-1:0] n_r [ISQRT_STAGES];

    always_comb begin
        logic [SQ_W-1:0] v;
        logic [SQ_W-1:0] r;
        logic [SQ_W-1:0] b;
        logic [SQ_W-1:0] t;
        for (int i = 0; i < ISQRT_STAGES; i++) begin
            if (i == 0) begin
                v = i_val;
                r = '0;
            end else begin
                v = r_v[i-1];
                r = r_r[i-1];
            end
            b = SQ_W'(1) << (SQ_W - 2 - 2 * i);
            t = r + b;
            if (v >= t) begin
                n_v[i] = v - t;
                n_r[i] = (r >> 1) + b;
            end else begin
                n_v[i] = v;
                n_r[i] = r >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < ISQRT_STAGES; i++) begin
                r_v[i] <= n_v[i];
                r_r[i] <= n_r[i];
            end
        end
    end

    assign o_root = r_r[ISQRT_STAGES-1][ROOT_W-1:0];

endmodule

[hdl/tifc_cordic.sv]
// ----------------------------------------------------------------------------
// tifc_cordic
// Pipelined vectoring CORDIC, one rotation per stage, angle in Q2.30.
// ----------------------------------------------------------------------------
module tifc_cordic import tifc_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic signed [CORD_W-1:0] i_x,
    input  logic signed [CORD_W-1:0] i_y,
    output logic signed [ANG_W-1:0]  o_z
);

    logic signed [CORD_W-1:0] r_x [ANGLE_ITERATIONS];
    logic signed [CORD_W-1:0] r_y [ANGLE_ITERATIONS];
    logic signed [ANG_W-1:0]  r_z [ANGLE_ITERATIONS];
    logic signed [CORD_W-1:0] n_x [ANGLE_ITERATIONS];
    logic signed [CORD_W-1:0] n_y [ANGLE_ITERATIONS];
    logic signed [ANG_W-1:0]  n_z [ANGLE_ITERATIONS];

    always_comb begin
        logic signed [CORD_W-1:0] x;
        logic signed [CORD_W-1:0] y;
        logic signed [ANG_W-1:0]  z;
        logic signed [CORD_W-1:0] xs;
        logic signed [CORD_W-1:0] ys;
        for (int i = 0; i < ANGLE_ITERATIONS; i++) begin
            if (i == 0) begin
                x = i_x;
                y = i_y;
                z = '0;
            end else begin
                x = r_x[i-1];
                y = r_y[i-1];
                z = r_z[i-1];
            end
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
                n_x[i] = x + ys;
                n_y[i] = y - xs;
                n_z[i] = z + atan_q30(i);
            end else begin
                n_x[i] = x - ys;
                n_y[i] = y + xs;
                n_z[i] = z - atan_q30(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < ANGLE_ITERATIONS; i++) begin
                r_x[i] <= n_x[i];
                r_y[i] <= n_y[i];
                r_z[i] <= n_z[i];
            end
        end
    end

    assign o_z = r_z[ANGLE_ITERATIONS-1];

endmodule

[hdl/transverse_isotropic_failure_check.sv]
// ----------------------------------------------------------------------------
// transverse_isotropic_failure_check
// Failure mode and crack normal for a transversely isotropic material.
// ----------------------------------------------------------------------------
// Throughput: one request per cycle while the output is not stalled; the
// 32-stage square root pipes and the CORDIC pipe each take one step per
// stage.
// A stall at the output freezes every stage at once.
// Reset (synchronous, active low) clears valid bits and loads register
// defaults: 3D geometry, all strengths at full scale.
module transverse_isotropic_failure_check import tifc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tifc_cfg_if.sink    i_cfg,
    tifc_in_if.sink     i_in,
    tifc_out_if.source  o_out
);

    logic w_en;

    logic             r_geom;
    logic [STR_W-1:0] r_ats;
    logic [STR_W-1:0] r_ass;
    logic [STR_W-1:0] r_tss;
    logic [STR_W-1:0] r_pts;
    logic [STR_W-1:0] r_pss;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_geom <= 1'b0;
            r_ats  <= '1;
            r_ass  <= '1;
            r_tss  <= '1;
            r_pts  <= '1;
            r_pss  <= '1;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_GEOMETRY:   r_geom <= i_cfg.data[0];
                REG_AXIAL_TENS: r_ats  <= i_cfg.data;
                REG_AXIAL_SHR:  r_ass  <= i_cfg.data;
                REG_TRANS_SHR:  r_tss  <= i_cfg.data;
                REG_PLANE_TENS: r_pts  <= i_cfg.data;
                REG_PLANE_SHR:  r_pss  <= i_cfg.data;
                default: ;
            endcase
        end
    end

    logic r_out_valid;
    assign w_en       = !r_out_valid || o_out.ready;
    assign i_in.ready = w_en;

    // stage 1: differences and magnitudes
    logic                       r1_v;
    logic signed [STRESS_W-1:0] r1_xx, r1_yy, r1_zz, r1_xy, r1_xz;
    logic [SCALE_W-1:0]         r1_scale;
    logic signed [STRESS_W:0]   r1_d;
    logic signed [STRESS_W-1:0] r1_ssum;
    logic [STRESS_W-1:0]        r1_ad, r1_axz, r1_ayz, r1_axy;
    logic signed [STRESS_W:0]   n1_d, n1_sum;

    always_comb begin
        n1_d   = {i_in.stress_xx[STRESS_W-1], i_in.stress_xx}
               - {i_in.stress_yy[STRESS_W-1], i_in.stress_yy};
        n1_sum = {i_in.stress_xx[STRESS_W-1], i_in.stress_xx}
               + {i_in.stress_yy[STRESS_W-1], i_in.stress_yy};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (w_en) begin
            r1_v <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_xx    <= i_in.stress_xx;
            r1_yy    <= i_in.stress_yy;
            r1_zz    <= i_in.stress_zz;
            r1_xy    <= i_in.stress_xy;
            r1_xz    <= i_in.stress_xz;
            r1_scale <= i_in.strength_scale;
            r1_d     <= n1_d;
            r1_ssum  <= n1_sum[STRESS_W:1];
            r1_ad    <= mag32(n1_d[STRESS_W:1]);
            r1_axz   <= mag32(i_in.stress_xz);
            r1_ayz   <= mag32(i_in.stress_yz);
            r1_axy   <= mag32(i_in.stress_xy);
        end
    end

    // stage 2: thresholds and squares
    logic                       r2_v;
    logic [THR_W-1:0]           r2_ta, r2_tas, r2_tts, r2_tp, r2_tps;
    logic [SQ_W-1:0]            r2_sq_xz, r2_sq_yz, r2_sq_d, r2_sq_xy;
    logic signed [STRESS_W-1:0] r2_xx, r2_yy, r2_zz, r2_xy, r2_xz;
    logic [STRESS_W-1:0]        r2_ayz, r2_axy;
    logic signed [STRESS_W:0]   r2_d;
    logic signed [STRESS_W-1:0] r2_ssum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (w_en) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_ta    <= thr(r_ats, r1_scale);
            r2_tas   <= thr(r_ass, r1_scale);
            r2_tts   <= thr(r_tss, r1_scale);
            r2_tp    <= thr(r_pts, r1_scale);
            r2_tps   <= thr(r_pss, r1_scale);
            r2_sq_xz <= SQ_W'(r1_axz) * SQ_W'(r1_axz);
            r2_sq_yz <= SQ_W'(r1_ayz) * SQ_W'(r1_ayz);
            r2_sq_d  <= SQ_W'(r1_ad) * SQ_W'(r1_ad);
            r2_sq_xy <= SQ_W'(r1_axy) * SQ_W'(r1_axy);
            r2_xx    <= r1_xx;
            r2_yy    <= r1_yy;
            r2_zz    <= r1_zz;
            r2_xy    <= r1_xy;
            r2_xz    <= r1_xz;
            r2_ayz   <= r1_ayz;
            r2_axy   <= r1_axy;
            r2_d     <= r1_d;
            r2_ssum  <= r1_ssum;
        end
    end

    // stage 3: sums of squares, early decisions
    logic            r3_v;
    logic [SQ_W-1:0] r3_msq, r3_ssq;
    t_sb             r3_sb;
    t_sb             n3_sb;

    always_comb begin
        n3_sb           = '0;
        n3_sb.geom2d    = r_geom;
        n3_sb.tw        = r_tss < r_ass;
        n3_sb.axial     = $signed({{16{r2_zz[STRESS_W-1]}}, r2_zz}) > $signed({1'b0, r2_ta});
        n3_sb.thr_shear = (r2_tas < r2_tts) ? r2_tas : r2_tts;
        n3_sb.tp        = r2_tp;
        n3_sb.tps       = r2_tps;
        n3_sb.ssum      = r2_ssum;
        n3_sb.d         = r2_d;
        n3_sb.xy        = r2_xy;
        n3_sb.xz        = r2_xz;
        n3_sb.ayz       = r2_ayz;
        n3_sb.mode2d    = MODE_NONE;
        if ($signed({{16{r2_yy[STRESS_W-1]}}, r2_yy}) > $signed({1'b0, r2_ta})) begin
            n3_sb.mode2d   = MODE_AXIAL_T;
            n3_sb.second2d = ONE_Q16;
        end else if (THR_W'(r2_axy) > r2_tas || THR_W'(r2_axy) > r2_tts) begin
            n3_sb.mode2d = MODE_AXIAL_S;
            if (n3_sb.tw) begin
                n3_sb.second2d = ONE_Q16;
            end else begin
                n3_sb.first2d = ONE_Q16;
            end
        end else if ($signed({{16{r2_xx[STRESS_W-1]}}, r2_xx}) > $signed({1'b0, r2_tp})) begin
            n3_sb.mode2d  = MODE_TRANS_T;
            n3_sb.first2d = ONE_Q16;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (w_en) begin
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_msq <= r2_sq_xz + r2_sq_yz;
            r3_ssq <= r2_sq_d + r2_sq_xy;
            r3_sb  <= n3_sb;
        end
    end

    // square roots
    logic [ROOT_W-1:0] w_m, w_s;
    logic              r_vq  [ISQRT_STAGES];
    t_sb               r_sbq [ISQRT_STAGES];

    tifc_isqrt u_isqrt_m (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_val  (r3_msq),
        .o_root (w_m)
    );

    tifc_isqrt u_isqrt_s (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_val  (r3_ssq),
        .o_root (w_s)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ISQRT_STAGES; i++) begin
                r_vq[i] <= 1'b0;
            end
        end else if (w_en) begin
            r_vq[0] <= r3_v;
            for (int i = 1; i < ISQRT_STAGES; i++) begin
                r_vq[i] <= r_vq[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sbq[0] <= r3_sb;
            for (int i = 1; i < ISQRT_STAGES; i++) begin
                r_sbq[i] <= r_sbq[i-1];
            end
        end
    end

    // stage 4: mode decision and CORDIC vector
    logic                    r4_v;
    t_ctl                    r4_ctl;
    logic signed [VEC_W-1:0] r4_vx, r4_vy;
    t_ctl                    n4_ctl;
    logic signed [VEC_W-1:0] n4_vx, n4_vy;

    always_comb begin
        t_sb                     sb;
        logic signed [TH_W-1:0]  sigma1;
        logic                    sig_ge;
        logic                    s_ge;
        logic signed [VEC_W-1:0] dx;
        logic signed [VEC_W-1:0] xy2;
        sb     = r_sbq[ISQRT_STAGES-1];
        sigma1 = $signed({{2{sb.ssum[STRESS_W-1]}}, sb.ssum}) + $signed({2'b0, w_s});
        sig_ge = $signed({{14{sigma1[TH_W-1]}}, sigma1}) >= $signed({1'b0, sb.tp});
        s_ge   = THR_W'(w_s) >= sb.tps;
        dx     = VEC_W'(sb.d);
        xy2    = VEC_W'({sb.xy, 1'b0});
        if (sb.xy < 0) begin
            xy2 = {{(VEC_W-STRESS_W-1){1'b1}}, sb.xy, 1'b0};
        end
        n4_ctl        = '0;
        n4_ctl.geom2d = sb.geom2d;
        n4_ctl.mode   = MODE_NONE;
        n4_vx         = '0;
        n4_vy         = '0;
        if (sb.geom2d) begin
            n4_ctl.mode       = sb.mode2d;
            n4_ctl.first_fix  = sb.first2d;
            n4_ctl.second_fix = sb.second2d;
        end else if (sb.axial) begin
            n4_ctl.mode       = MODE_AXIAL_T;
            n4_ctl.second_fix = HALF_PI_Q16;
        end else if (THR_W'(w_m) > sb.thr_shear) begin
            n4_ctl.mode = MODE_AXIAL_S;
            if (sb.tw) begin
                n4_ctl.second_fix = HALF_PI_Q16;
            end else begin
                n4_ctl.ang_direct = 1'b1;
                n4_vx             = VEC_W'(sb.ayz);
                n4_vy             = VEC_W'(sb.xz);
            end
        end else if (sig_ge || s_ge) begin
            n4_ctl.mode          = sig_ge ? MODE_TRANS_T : MODE_TRANS_S;
            n4_ctl.ang_principal = 1'b1;
            if (sb.d == 0) begin
                n4_ctl.half_fix   = 1'b1;
                n4_ctl.take_first = sb.xy > 0;
            end else if (sb.d > 0) begin
                n4_ctl.take_first = 1'b1;
                n4_vx             = dx;
                n4_vy             = xy2;
            end else begin
                n4_vx = -dx;
                n4_vy = -xy2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (w_en) begin
            r4_v <= r_vq[ISQRT_STAGES-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_ctl <= n4_ctl;
            r4_vx  <= n4_vx;
            r4_vy  <= n4_vy;
        end
    end

    // stage 5: normalizing shift count
    logic                    r5_v;
    t_ctl                    r5_ctl;
    logic signed [VEC_W-1:0] r5_vx, r5_vy;
    logic [SHIFT_W-1:0]      r5_k;
    logic [SHIFT_W-1:0]      n5_k;

    always_comb begin
        logic signed [VEC_W-1:0] ay;
        logic [VEC_W-1:0]        orv;
        logic [SHIFT_W-1:0]      p;
        ay  = (r4_vy < 0) ? -r4_vy : r4_vy;
        orv = r4_vx | ay;
        p   = '0;
        for (int b = 0; b < VEC_W; b++) begin
            if (orv[b]) begin
                p = SHIFT_W'(b);
            end
        end
        n5_k = SHIFT_W'(NORM_EXP) - p;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else if (w_en) begin
            r5_v <= r4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_ctl <= r4_ctl;
            r5_vx  <= r4_vx;
            r5_vy  <= r4_vy;
            r5_k   <= n5_k;
        end
    end

    // stage 6: normalize
    logic                     r6_v;
    t_ctl                     r6_ctl;
    logic signed [CORD_W-1:0] r6_x, r6_y;
    logic signed [CORD_W-1:0] n6_x, n6_y;

    always_comb begin
        n6_x = CORD_W'(r5_vx);
        n6_y = CORD_W'(r5_vy);
        n6_x = n6_x <<< r5_k;
        n6_y = n6_y <<< r5_k;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_v <= 1'b0;
        end else if (w_en) begin
            r6_v <= r5_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r6_ctl <= r5_ctl;
            r6_x   <= n6_x;
            r6_y   <= n6_y;
        end
    end

    // CORDIC
    logic signed [ANG_W-1:0] w_z;
    logic                    r_vc  [ANGLE_ITERATIONS];
    t_ctl                    r_ctq [ANGLE_ITERATIONS];

    tifc_cordic u_cordic (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_x   (r6_x),
        .i_y   (r6_y),
        .o_z   (w_z)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ANGLE_ITERATIONS; i++) begin
                r_vc[i] <= 1'b0;
            end
        end else if (w_en) begin
            r_vc[0] <= r6_v;
            for (int i = 1; i < ANGLE_ITERATIONS; i++) begin
                r_vc[i] <= r_vc[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ctq[0] <= r6_ctl;
            for (int i = 1; i < ANGLE_ITERATIONS; i++) begin
                r_ctq[i] <= r_ctq[i-1];
            end
        end
    end

    // stage 7: principal angle
    logic                   r7_v;
    t_ctl                   r7_ctl;
    logic signed [TH_W-1:0] r7_th;
    logic signed [TH_W-1:0] n7_th;

    always_comb begin
        t_ctl                   c;
        logic signed [TH_W-1:0] tt;
        logic signed [TH_W-1:0] tsum;
        c     = r_ctq[ANGLE_ITERATIONS-1];
        tt    = c.half_fix ? HALF_PI_Q30 : TH_W'(w_z);
        tsum  = c.take_first ? tt : (tt + PI_Q30);
        n7_th = TH_W'(w_z);
        if (c.ang_principal) begin
            n7_th = tsum >>> 1;
            if (c.mode == MODE_TRANS_S) begin
                n7_th = n7_th - QUARTER_PI_Q30;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_v <= 1'b0;
        end else if (w_en) begin
            r7_v <= r_vc[ANGLE_ITERATIONS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r7_ctl <= r_ctq[ANGLE_ITERATIONS-1];
            r7_th  <= n7_th;
        end
    end

    // output register
    logic                     r_out_geom;
    logic [MODE_W-1:0]        r_out_mode;
    logic signed [NORM_W-1:0] r_out_first, r_out_second;
    logic signed [NORM_W-1:0] n_first, n_second;

    always_comb begin
        logic signed [TH_W-1:0] rnd;
        rnd      = (r7_th + ROUND_Q30) >>> 14;
        n_first  = r7_ctl.first_fix;
        n_second = r7_ctl.second_fix;
        if (r7_ctl.ang_direct || r7_ctl.ang_principal) begin
            n_first  = rnd[NORM_W-1:0];
            n_second = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= r7_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_geom   <= r7_ctl.geom2d;
            r_out_mode   <= r7_ctl.mode;
            r_out_first  <= n_first;
            r_out_second <= n_second;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.failure_mode  = r_out_mode;
    assign o_out.normal_first  = r_out_first;
    assign o_out.normal_second = r_out_second;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.failure_mode == MODE_NONE
        |-> o_out.normal_first == '0 && o_out.normal_second == '0)
        else $error("no-failure result carries a nonzero normal");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !r_out_geom && o_out.failure_mode == MODE_AXIAL_T
        |-> o_out.normal_first == '0 && o_out.normal_second == HALF_PI_Q16)
        else $error("3D axial tension with wrong angles");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && r_out_geom && o_out.failure_mode != MODE_NONE
        |-> (o_out.normal_first == ONE_Q16 && o_out.normal_second == '0)
         || (o_out.normal_first == '0 && o_out.normal_second == ONE_Q16))
        else $error("2D normal is not a unit axis");

endmodule

[tb/sv/tifc_failure_scoreboard.sv]
// ----------------------------------------------------------------------------
// tifc_failure_scoreboard
// Watches the stress, result and register channels, predicts failure mode and
// crack normal for each accepted request, and compares results in order.
// ----------------------------------------------------------------------------
module tifc_failure_scoreboard import tifc_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    tifc_cfg_if    cfg,
    tifc_in_if     req,
    tifc_out_if    rsp,
    output int     o_fail_count,
    output int     o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [MODE_W-1:0]        mode;
        logic signed [NORM_W-1:0] first;
        logic signed [NORM_W-1:0] second;
    } t_crack;

    localparam longint PI_L      = 64'sd3373259426;
    localparam longint HALF_PI_L = 64'sd1686629713;
    localparam longint QTR_PI_L  = 64'sd843314857;
    localparam longint NORM_LIM  = 64'sd1 <<< 40;

    logic          geom_2d;
    longint        str_axial_t, str_axial_s, str_trans_s, str_plane_t, str_plane_s;
    t_crack        crack_q[$];
    int            fails = 0;

    assign o_fail_count = fails;
    assign o_pending    = crack_q.size();

    function automatic longint floor_shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint floor_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return longint'(r);
    endfunction

    function automatic longint vector_angle(longint x, longint y);
        longint z, xs, ys;
        z = 0;
        if (x == 0 && y == 0) return 0;
        while (x < NORM_LIM && y < NORM_LIM && y > -NORM_LIM) begin
            x = x * 2;
            y = y * 2;
        end
        for (int i = 0; i < ANGLE_ITERATIONS; i++) begin
            xs = floor_shr(x, i);
            ys = floor_shr(y, i);
            if (y > 0) begin
                x = x + ys; y = y - xs; z = z + longint'(atan_q30(i));
            end else begin
                x = x - ys; y = y + xs; z = z - longint'(atan_q30(i));
            end
        end
        return z;
    endfunction

    function automatic logic signed [NORM_W-1:0] to_q16(longint a);
        longint r;
        r = floor_shr(a + 8192, 14);
        return r[NORM_W-1:0];
    endfunction

    function automatic longint limit(longint s, longint unsigned k);
        longint unsigned p;
        p = longint'(s) * k;
        return longint'(p >> 16);
    endfunction

    function automatic t_crack predict_crack(longint xx, longint yy, longint zz, longint xy,
                                             longint xz, longint yz, longint unsigned k);
        t_crack c;
        longint ta, tas, tts, tp, tps, m, ssum, sdif, s, sig1, d, two_t, th, axy;
        logic weak_t, take_first;
        ta  = limit(str_axial_t, k);
        tas = limit(str_axial_s, k);
        tts = limit(str_trans_s, k);
        tp  = limit(str_plane_t, k);
        tps = limit(str_plane_s, k);
        weak_t = str_trans_s < str_axial_s;
        c.mode = MODE_NONE;
        c.first = '0;
        c.second = '0;
        if (!geom_2d) begin
            if (xz < 0) xz = -xz;
            m = floor_sqrt(longint'(xz * xz) + longint'((yz < 0 ? -yz : yz) ** 2));
            if (zz > ta) begin
                c.mode = MODE_AXIAL_T;
                c.second = to_q16(HALF_PI_L);
            end else if (m > tas || m > tts) begin
                c.mode = MODE_AXIAL_S;
                if (weak_t) c.second = to_q16(HALF_PI_L);
                else c.first = to_q16(vector_angle(yz < 0 ? -yz : yz,
                                                   req.stress_xz));
            end else begin
                ssum = floor_shr(xx + yy, 1);
                sdif = floor_shr(xx - yy, 1);
                if (sdif < 0) sdif = -sdif;
                axy = xy < 0 ? -xy : xy;
                s = floor_sqrt(sdif * sdif + axy * axy);
                sig1 = ssum + s;
                if (sig1 >= tp || s >= tps) begin
                    d = xx - yy;
                    if (d == 0) begin
                        two_t = HALF_PI_L;
                        take_first = xy > 0;
                    end else begin
                        two_t = vector_angle(d > 0 ? d : -d, d > 0 ? 2 * xy : -2 * xy);
                        take_first = d > 0;
                    end
                    th = take_first ? floor_shr(two_t, 1) : floor_shr(two_t + PI_L, 1);
                    if (sig1 < tp) begin
                        c.mode = MODE_TRANS_S;
                        th = th - QTR_PI_L;
                    end else begin
                        c.mode = MODE_TRANS_T;
                    end
                    c.first = to_q16(th);
                end
            end
        end else begin
            axy = xy < 0 ? -xy : xy;
            if (yy > ta) begin
                c.mode = MODE_AXIAL_T;
                c.second = ONE_Q16;
            end else if (axy > tas || axy > tts) begin
                c.mode = MODE_AXIAL_S;
                if (weak_t) c.second = ONE_Q16;
                else c.first = ONE_Q16;
            end else if (xx > tp) begin
                c.mode = MODE_TRANS_T;
                c.first = ONE_Q16;
            end
        end
        return c;
    endfunction

    task automatic report(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        fails++;
    endtask

    always @(posedge i_clk) begin
        t_crack want;
        if (!i_rst_n) begin
            geom_2d     <= 1'b0;
            str_axial_t <= 64'h7FFF_FFFF;
            str_axial_s <= 64'h7FFF_FFFF;
            str_trans_s <= 64'h7FFF_FFFF;
            str_plane_t <= 64'h7FFF_FFFF;
            str_plane_s <= 64'h7FFF_FFFF;
        end else begin
            if (cfg.valid && cfg.ready) begin
                case (cfg.index)
                    REG_GEOMETRY:   geom_2d     <= cfg.data[0];
                    REG_AXIAL_TENS: str_axial_t <= longint'(cfg.data);
                    REG_AXIAL_SHR:  str_axial_s <= longint'(cfg.data);
                    REG_TRANS_SHR:  str_trans_s <= longint'(cfg.data);
                    REG_PLANE_TENS: str_plane_t <= longint'(cfg.data);
                    REG_PLANE_SHR:  str_plane_s <= longint'(cfg.data);
                    default: ;
                endcase
            end
            if (req.valid && req.ready) begin
                crack_q.push_back(predict_crack(req.stress_xx, req.stress_yy, req.stress_zz,
                    req.stress_xy, req.stress_xz, req.stress_yz,
                    longint'(req.strength_scale)));
            end
            if (rsp.valid && rsp.ready) begin
                if (crack_q.size() == 0) begin
                    report("unexpected result, mode", rsp.failure_mode, -1);
                end else begin
                    want = crack_q.pop_front();
                    if (rsp.failure_mode !== want.mode)
                        report("failure_mode", rsp.failure_mode, want.mode);
                    if (rsp.normal_first !== want.first)
                        report("normal_first", rsp.normal_first, want.first);
                    if (rsp.normal_second !== want.second)
                        report("normal_second", rsp.normal_second, want.second);
                end
            end
        end
    end

endmodule

[tb/sv/transverse_isotropic_failure_check_tb.sv]
// ----------------------------------------------------------------------------
// transverse_isotropic_failure_check_tb
// Drives directed and random stress requests through several register
// settings with random gaps and stalls; the scoreboard gives the verdict.
// ----------------------------------------------------------------------------
module transverse_isotropic_failure_check_tb;
    import tifc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY     = 40 + ANGLE_ITERATIONS;
    localparam int MAX_CYCLE   = 400000;
    localparam int HOLD_CYCLES = 300;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   fail_count, pending, cycle;
    int   hold_off = 0;
    logic hold_req = 1'b0;
    logic hold_seen = 1'b0;

    tifc_cfg_if cfg ();
    tifc_in_if  req ();
    tifc_out_if rsp ();

    transverse_isotropic_failure_check dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(cfg), .i_in(req), .o_out(rsp)
    );

    tifc_failure_scoreboard scb (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .cfg(cfg), .req(req), .rsp(rsp),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (cycle > MAX_CYCLE) begin
            $display("[transverse_isotropic_failure_check] ERROR");
            $finish;
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Result side: random stalls, one long hold-off on request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp.ready <= 1'b0;
        end else if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_off  <= HOLD_CYCLES;
            rsp.ready <= 1'b0;
        end else if (hold_off > 0) begin
            rsp.ready <= 1'b0;
            hold_off <= hold_off - 1;
        end else begin
            rsp.ready <= (gap_len() == 0) || ($urandom_range(0, 3) == 0);
        end
    end

    function automatic logic [31:0] rand_stress(int kind);
        case (kind)
            0: return $urandom;
            1: return $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
            2: return $signed($urandom_range(0, 32'h0000_4000)) - 32'sh0000_2000;
            default: begin
                case ($urandom_range(0, 4))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'h0;
                    3: return 32'hFFFF_FFFF;
                    default: return 32'h1;
                endcase
            end
        endcase
    endfunction

    task automatic send(logic [31:0] xx, logic [31:0] yy, logic [31:0] zz, logic [31:0] xy,
                        logic [31:0] xz, logic [31:0] yz, logic [31:0] k);
        int g;
        g = gap_len();
        repeat (g) begin
            req.valid <= 1'b0;
            @(posedge i_clk);
        end
        req.valid <= 1'b1;
        req.stress_xx <= xx; req.stress_yy <= yy; req.stress_zz <= zz;
        req.stress_xy <= xy; req.stress_xz <= xz; req.stress_yz <= yz;
        req.strength_scale <= k;
        @(posedge i_clk);
        while (!req.ready) @(posedge i_clk);
    endtask

    task automatic send_random(int n);
        int kind;
        logic [31:0] k, xx, yy;
        for (int i = 0; i < n; i++) begin
            kind = $urandom_range(0, 3);
            k = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 32'h0002_0000);
            xx = rand_stress(kind);
            yy = ($urandom_range(0, 7) == 0) ? xx : rand_stress(kind);
            send(xx, yy, rand_stress(kind), ($urandom_range(0, 9) == 0) ? 32'h0 : rand_stress(kind),
                 rand_stress(kind), rand_stress(kind), k);
        end
        req.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [STR_W-1:0] val);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= val;
        @(posedge i_clk);
        while (!cfg.ready) @(posedge i_clk);
        cfg.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_strengths(logic g, logic [STR_W-1:0] a, logic [STR_W-1:0] b,
                                 logic [STR_W-1:0] c, logic [STR_W-1:0] d,
                                 logic [STR_W-1:0] e);
        write_reg(REG_GEOMETRY, {30'd0, g});
        write_reg(REG_AXIAL_TENS, a);
        write_reg(REG_AXIAL_SHR, b);
        write_reg(REG_TRANS_SHR, c);
        write_reg(REG_PLANE_TENS, d);
        write_reg(REG_PLANE_SHR, e);
    endtask

    initial begin
        cfg.valid = 1'b0; cfg.index = '0; cfg.data = '0;
        req.valid = 1'b0; req.stress_xx = '0; req.stress_yy = '0; req.stress_zz = '0;
        req.stress_xy = '0; req.stress_xz = '0; req.stress_yz = '0;
        req.strength_scale = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, reset defaults then moderate strengths
        send(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0, 32'h0);
        send(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
             32'h8000_0000, 32'hFFFF_FFFF);
        send(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0001_0000);
        req.valid <= 1'b0;
        drain();
        set_strengths(1'b0, 31'h0003_0000, 31'h0002_0000, 31'h0004_0000, 31'h0001_8000,
                      31'h0001_0000);
        send(32'h0, 32'h0, 32'h0004_0000, 32'h0, 32'h0, 32'h0, 32'h0001_0000);
        send(32'h0, 32'h0, 32'h0, 32'h0, 32'h0003_0000, 32'hFFFD_0000, 32'h0001_0000);
        send(32'h0, 32'h0, 32'h0, 32'h0, 32'hFFFD_0000, 32'h0, 32'h0001_0000);
        send(32'h0002_0000, 32'h0002_0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0001_0000);
        send(32'h0002_0000, 32'h0002_0000, 32'h0, 32'h0001_0000, 32'h0, 32'h0, 32'h0001_0000);
        send(32'h0, 32'h0, 32'h0, 32'hFFFE_0000, 32'h0, 32'h0, 32'h0001_0000);
        send(32'h0002_0000, 32'h0001_0000, 32'h0, 32'h0000_8000, 32'h0, 32'h0, 32'h0001_0000);
        send(32'hFFFE_0000, 32'h0002_0000, 32'h0, 32'h0001_8000, 32'h0, 32'h0, 32'h0001_0000);
        send(32'hFFFE_0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0001_0000);
        req.valid <= 1'b0;
        drain();
        set_strengths(1'b1, 31'h0003_0000, 31'h0004_0000, 31'h0002_0000, 31'h0001_8000,
                      31'h0001_0000);
        send(32'h0, 32'h0004_0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0001_0000);
        send(32'h0, 32'h0, 32'h0, 32'hFFFD_0000, 32'h0, 32'h0, 32'h0001_0000);
        send(32'h0002_0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0001_0000);
        send(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0001_0000);
        send_random(150);
        drain();

        // long hold-off while the sender keeps offering
        hold_req <= ~hold_req;
        send_random(150);
        drain();

        set_strengths(1'b0, 31'h0, 31'h0, 31'h0, 31'h0, 31'h0);
        send_random(150);
        drain();
        set_strengths(1'b0, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
                      31'h7FFF_FFFF);
        send_random(150);
        drain();
        for (int p = 0; p < 8; p++) begin
            set_strengths($urandom_range(0, 1) == 0 ? 1'b0 : ($urandom_range(0, 2) == 0),
                          STR_W'($urandom_range(0, 32'h0008_0000)),
                          STR_W'($urandom_range(0, 32'h0008_0000)),
                          STR_W'($urandom_range(0, 32'h0008_0000)),
                          STR_W'($urandom_range(0, 32'h0008_0000)),
                          STR_W'($urandom_range(0, 32'h0008_0000)));
            send_random(150);
            drain();
        end
        drain();
        if (fail_count == 0) begin
            $display("[transverse_isotropic_failure_check] OK");
        end else begin
            $display("[transverse_isotropic_failure_check] ERROR");
        end
        $finish;
    end
endmodule

[files.f]
hdl/tifc_pkg.sv
hdl/tifc_in_if.sv
hdl/tifc_out_if.sv
hdl/tifc_cfg_if.sv
hdl/tifc_isqrt.sv
hdl/tifc_cordic.sv
hdl/transverse_isotropic_failure_check.sv
tb/sv/tifc_failure_scoreboard.sv
tb/sv/transverse_isotropic_failure_check_tb.sv
